### rtl/assert_macros.svh
// Assertion macros shared by the integer square root RTL.
// No dependencies; files that check their logic include this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`endif

### rtl/isr_pkg.sv
// Package for the integer square root: fixed field widths of the streams and of a round.
// No dependencies; imported by the cell and the top level.
`default_nettype none

package isr_pkg;

	// Width of the radicand field on the input stream.
	localparam int unsigned RADICAND_W = 64;

	// Width of the root field on the output stream.
	localparam int unsigned ROOT_W = 32;

	// Radicand bits brought down into the remainder in each round.
	localparam int unsigned PAIR_W = 2;

endpackage

`default_nettype wire

### rtl/isr_cell.sv
// One round of the digit-by-digit square root, with its own output register.
// Depends on isr_pkg; instantiated in a row by integer_square_root.
`default_nettype none

module isr_cell
	import isr_pkg::*;
#(
	parameter int unsigned ROOT_BITS = 32,
	parameter int unsigned REST_BITS = 64
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// Upstream side.
	input  wire logic                   in_valid,
	output      logic                   in_ready,
	input  wire logic [ROOT_BITS+1:0]   in_rem,
	input  wire logic [ROOT_BITS-1:0]   in_root,
	input  wire logic [REST_BITS-1:0]   in_rest,
	// Downstream side.
	output      logic                   out_valid,
	input  wire logic                   out_ready,
	output      logic [ROOT_BITS+1:0]   out_rem,
	output      logic [ROOT_BITS-1:0]   out_root,
	output      logic [REST_BITS-1:0]   out_rest
);

	localparam int unsigned REM_BITS = ROOT_BITS + 2;

	logic                  valid_q;
	logic [REM_BITS-1:0]   rem_q;
	logic [ROOT_BITS-1:0]  root_q;
	logic [REST_BITS-1:0]  rest_q;

	logic [REM_BITS-1:0]   rem_sh;
	logic [REM_BITS-1:0]   trial;
	logic [REM_BITS:0]     diff;
	logic                  root_bit;
	logic [REM_BITS-1:0]   rem_next;
	logic [ROOT_BITS-1:0]  root_next;
	logic [REST_BITS-1:0]  rest_next;

	// Bring the next radicand pair down and try to subtract 4r+1.
	always_comb begin
		rem_sh    = {in_rem[REM_BITS-PAIR_W-1:0], in_rest[REST_BITS-1 -: PAIR_W]};
		trial     = {in_root, 2'b01};
		diff      = {1'b0, rem_sh} - {1'b0, trial};
		root_bit  = ~diff[REM_BITS];
		rem_next  = root_bit ? diff[REM_BITS-1:0] : rem_sh;
		root_next = ROOT_BITS'({in_root, root_bit});
		rest_next = in_rest << PAIR_W;
	end

	// The cell takes a new transfer when empty or when its content moves on.
	assign in_ready = ~valid_q | out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	// Payload registers load only with a transfer.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			rem_q  <= rem_next;
			root_q <= root_next;
			rest_q <= rest_next;
		end
	end

	assign out_valid = valid_q;
	assign out_rem   = rem_q;
	assign out_root  = root_q;
	assign out_rest  = rest_q;

endmodule

`default_nettype wire

### rtl/integer_square_root.sv
// Each input transfer passes through a row of registered cells, each holding its own item,
// one cell in the row for each root bit.
// Throughput: one radicand per cycle while m_tready is high; a cell stalls only if full.
// Reset clears the valid bit of every cell; payload registers are not reset.
// Top level of the integer square root; depends on isr_pkg, isr_cell and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module integer_square_root
	import isr_pkg::*;
#(
	parameter int unsigned RADICAND_BITS = 64
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// Input stream.
	input  wire logic                  s_tvalid,
	output      logic                  s_tready,
	input  wire logic [RADICAND_W-1:0] s_tdata,  // [63:0] radicand
	// Output stream.
	output      logic                  m_tvalid,
	input  wire logic                  m_tready,
	output      logic [ROOT_W-1:0]     m_tdata   // [31:0] root
);

	localparam int unsigned ROUNDS    = (RADICAND_BITS + 1) / 2;
	localparam int unsigned REST_BITS = 2 * ROUNDS;
	localparam int unsigned REM_BITS  = ROUNDS + 2;

	logic                 valid [ROUNDS+1];
	logic                 ready [ROUNDS+1];
	logic [REM_BITS-1:0]  rem   [ROUNDS+1];
	logic [ROUNDS-1:0]    root  [ROUNDS+1];
	logic [REST_BITS-1:0] rest  [ROUNDS+1];

	// Head of the row: bits above the datapath width are dropped.
	assign valid[0] = s_tvalid;
	assign s_tready = ready[0];
	assign rem[0]   = '0;
	assign root[0]  = '0;
	assign rest[0]  = REST_BITS'(s_tdata[RADICAND_BITS-1:0]);

	// One cell per root bit, most significant bit first.
	for (genvar i = 0; i < ROUNDS; i++) begin : g_cell
		isr_cell #(
			.ROOT_BITS (ROUNDS),
			.REST_BITS (REST_BITS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (valid[i]),
			.in_ready  (ready[i]),
			.in_rem    (rem[i]),
			.in_root   (root[i]),
			.in_rest   (rest[i]),
			.out_valid (valid[i+1]),
			.out_ready (ready[i+1]),
			.out_rem   (rem[i+1]),
			.out_root  (root[i+1]),
			.out_rest  (rest[i+1])
		);
	end

	// The last cell's register is the output register.
	assign ready[ROUNDS] = m_tready;
	assign m_tvalid      = valid[ROUNDS];
	assign m_tdata       = ROOT_W'(root[ROUNDS]);

	// A finished root leaves a remainder of at most twice the root.
	`ASSERT_IMPL(a_rem_bound, clk, arst_n, m_tvalid, rem[ROUNDS] <= {1'b0, root[ROUNDS], 1'b0})
	// Every radicand pair has been consumed by the end of the row.
	`ASSERT_IMPL(a_rest_used, clk, arst_n, m_tvalid, rest[ROUNDS] == '0)
	// An empty output register never holds back the row.
	`ASSERT_IMPL(a_out_empty_ready, clk, arst_n, !m_tvalid, s_tready)
	// A transfer into the row fills the first cell on the next cycle.
	`ASSERT_NEXT(a_first_fill, clk, arst_n, s_tvalid && s_tready, valid[1])

endmodule

`default_nettype wire
